// ===== rtl/four_level_page_table_updater_defines.svh =====
// Assertion helpers used by the updater RTL to check its own logic.
`ifndef FOUR_LEVEL_PAGE_TABLE_UPDATER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_UPDATER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPTU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fptu_pkg.sv =====
package fptu_pkg;

  // Table store geometry.
  localparam int TABLE_SLOTS   = 64;
  localparam int SLOT_W        = $clog2(TABLE_SLOTS);
  localparam int CNT_W         = $clog2(TABLE_SLOTS + 1);
  localparam int IDX_W         = 9;
  localparam int ADDR_W        = SLOT_W + IDX_W;
  localparam int TABLE_ENTRIES = TABLE_SLOTS << IDX_W;

  // Field widths.
  localparam int ENTRY_W = 64;
  localparam int FRAME_W = 40;
  localparam int VPAGE_W = 36;
  localparam int USED_W  = 7;
  localparam int OFFS_W  = 12;

  // Entry bits.
  localparam int PRESENT_BIT = 0;
  localparam int USER_BIT    = 2;
  localparam logic [OFFS_W-1:0] LINK_FLAGS = OFFS_W'(7);
  localparam logic [1:0] LEAF_LEVEL = 2'd3;

  // Operation codes.
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  // Status codes.
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [VPAGE_W-1:0] virt_page;
    logic [FRAME_W-1:0] phys_frame;
    logic [ENTRY_W-1:0] entry_flags;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              invalidate;
    logic [USED_W-1:0] slots_in_use;
  } result_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ZERO
  } state_t;

endpackage

// ===== rtl/four_level_page_table_updater.sv =====
// Channel   | Direction | Signals                       | Handshake
// ----------+-----------+-------------------------------+------------------------------
// request   | in        | req                           | taken when start && !busy
// result    | out       | result                        | one cycle, marked by result_valid
// config    | in        | cfg_wr_en, cfg_wr_data        | written when cfg_wr_en is high
//
// A request walks four levels through one table memory with a read and a write port,
// with a read state and an evaluate state per level (ST_READ, ST_EVAL).
// Every missing level that a map allocates adds a pass through ST_ZERO to clear the fresh slot.
// After reset the root slot is cleared, one entry a cycle, with busy high.
// The result is shown for one cycle only; the receiver cannot stall it.
`include "four_level_page_table_updater_defines.svh"

module four_level_page_table_updater (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  fptu_pkg::req_t                  req,
  input  logic                            cfg_wr_en,
  input  logic [fptu_pkg::FRAME_W-1:0]    cfg_wr_data,
  output logic                            result_valid,
  output fptu_pkg::result_t               result
);
  import fptu_pkg::*;

  // Table memory.
  logic [ENTRY_W-1:0] table_mem [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;

  // Sequencer state.
  state_t             state, state_next;
  logic [1:0]         level, level_next;
  logic [SLOT_W-1:0]  slot, slot_next;
  req_t               req_q, req_q_next;
  logic [CNT_W-1:0]   next_free, next_free_next;
  logic [SLOT_W-1:0]  zero_slot, zero_slot_next;
  logic [IDX_W-1:0]   zero_idx, zero_idx_next;
  logic [FRAME_W-1:0] base_frame;
  logic               result_valid_next;
  result_t            result_next;

  // Walk datapath.
  logic [IDX_W-1:0]   cur_idx;
  logic               present;
  logic [FRAME_W-1:0] link_rel;
  logic               link_ok;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame <= '0;
    end else if (cfg_wr_en) begin
      base_frame <= cfg_wr_data;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[mem_raddr];
  end

  // Pick the index of the current level.
  always_comb begin
    case (level)
      2'd0:    cur_idx = req_q.virt_page[4*IDX_W-1:3*IDX_W];
      2'd1:    cur_idx = req_q.virt_page[3*IDX_W-1:2*IDX_W];
      2'd2:    cur_idx = req_q.virt_page[2*IDX_W-1:IDX_W];
      default: cur_idx = req_q.virt_page[IDX_W-1:0];
    endcase
  end

  assign mem_raddr = {slot, cur_idx};

  // Decode the entry just read as a link to a lower table.
  assign present  = rd_data[PRESENT_BIT];
  assign link_rel = rd_data[OFFS_W+FRAME_W-1:OFFS_W] - base_frame;
  assign link_ok  = link_rel < FRAME_W'(next_free);

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      next_free    <= CNT_W'(1);
      zero_idx     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      next_free    <= next_free_next;
      zero_idx     <= zero_idx_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    level     <= level_next;
    slot      <= slot_next;
    req_q     <= req_q_next;
    zero_slot <= zero_slot_next;
    result    <= result_next;
  end

  // Next state, memory writes and result.
  always_comb begin
    state_next        = state;
    level_next        = level;
    slot_next         = slot;
    req_q_next        = req_q;
    next_free_next    = next_free;
    zero_slot_next    = zero_slot;
    zero_idx_next     = zero_idx;
    result_valid_next = 1'b0;
    result_next       = result;
    mem_we            = 1'b0;
    mem_waddr         = {slot, cur_idx};
    mem_wdata         = '0;

    case (state)
      // Clear the root slot after reset.
      ST_INIT: begin
        mem_we        = 1'b1;
        mem_waddr     = {SLOT_W'(0), zero_idx};
        zero_idx_next = zero_idx + IDX_W'(1);
        if (zero_idx == '1) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_q_next = req;
          level_next = 2'd0;
          slot_next  = '0;
          state_next = ST_READ;
        end
      end

      ST_READ: begin
        state_next = ST_EVAL;
      end

      ST_EVAL: begin
        result_next.invalidate   = 1'b0;
        result_next.slots_in_use = USED_W'(next_free);
        if (level != LEAF_LEVEL) begin
          if (req_q.operation == OP_MAP) begin
            if (!present) begin
              if (next_free >= CNT_W'(TABLE_SLOTS)) begin
                result_next.status = STATUS_NO_SLOT;
                result_valid_next  = 1'b1;
                state_next         = ST_IDLE;
              end else begin
                // Link a fresh slot, then clear it.
                mem_we         = 1'b1;
                mem_wdata      = {{(ENTRY_W-FRAME_W-OFFS_W){1'b0}},
                                  base_frame + FRAME_W'(next_free), LINK_FLAGS};
                next_free_next = next_free + CNT_W'(1);
                zero_slot_next = next_free[SLOT_W-1:0];
                zero_idx_next  = '0;
                state_next     = ST_ZERO;
              end
            end else begin
              if (req_q.entry_flags[USER_BIT]) begin
                mem_we              = 1'b1;
                mem_wdata           = rd_data;
                mem_wdata[USER_BIT] = 1'b1;
              end
              if (link_ok) begin
                slot_next  = link_rel[SLOT_W-1:0];
                level_next = level + 2'd1;
                state_next = ST_READ;
              end else begin
                result_next.status = STATUS_NO_SLOT;
                result_valid_next  = 1'b1;
                state_next         = ST_IDLE;
              end
            end
          end else begin
            if (present && link_ok) begin
              slot_next  = link_rel[SLOT_W-1:0];
              level_next = level + 2'd1;
              state_next = ST_READ;
            end else begin
              result_next.status = STATUS_NOT_FOUND;
              result_valid_next  = 1'b1;
              state_next         = ST_IDLE;
            end
          end
        end else begin
          // Leaf level.
          result_valid_next = 1'b1;
          state_next        = ST_IDLE;
          if (req_q.operation == OP_MAP) begin
            mem_we             = 1'b1;
            mem_wdata          = {{(ENTRY_W-FRAME_W-OFFS_W){1'b0}},
                                  req_q.phys_frame, {OFFS_W{1'b0}}}
                                 | req_q.entry_flags;
            result_next.status = STATUS_DONE;
          end else if (present) begin
            mem_we                 = 1'b1;
            mem_wdata              = '0;
            result_next.status     = STATUS_DONE;
            result_next.invalidate = 1'b1;
          end else begin
            result_next.status = STATUS_NOT_FOUND;
          end
        end
      end

      // Clear a freshly allocated slot, then descend into it.
      ST_ZERO: begin
        mem_we        = 1'b1;
        mem_waddr     = {zero_slot, zero_idx};
        zero_idx_next = zero_idx + IDX_W'(1);
        if (zero_idx == '1) begin
          slot_next  = zero_slot;
          level_next = level + 2'd1;
          state_next = ST_READ;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  // Checks on the sequencer.
  `FPTU_ASSERT_SAME(a_result_when_idle, result_valid, !busy,
    "result shown while a request is still in progress")
  `FPTU_ASSERT_NEXT(a_start_makes_busy, start && !busy, busy,
    "accepted request did not make the block busy")
  `FPTU_ASSERT_NEXT(a_single_strobe, result_valid, !result_valid,
    "result strobe lasted more than one cycle")
  `FPTU_ASSERT_SAME(a_inval_only_done, result_valid && result.invalidate,
    result.status == STATUS_DONE, "invalidate raised on a failed request")
  `FPTU_ASSERT_SAME(a_free_count_range, 1'b1,
    next_free >= CNT_W'(1) && next_free <= CNT_W'(TABLE_SLOTS),
    "slot counter left its range")

endmodule
